// ===== src/bfa_pkg.sv =====
// Shared types, codes and field widths for the bitmap fit allocator.
`default_nettype none

package bfa_pkg;

  // Field widths of the item and result channels
  localparam int unsigned REQ_W  = 1;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned MODE_W = 2;

  // Default store size in cells
  localparam int unsigned CELLS_DEF = 64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 1'b1;

  // Placement policy
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_e;

  // Per-cycle control from the sequencer to the run scanner
  typedef struct packed {
    logic clear;  // start of a new scan
    logic step;   // one cell presented this cycle
    logic occ;    // presented cell is occupied (or past the end)
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== src/bfa_cfg_if.sv =====
// Configuration write channel carrying the placement policy.
`default_nettype none

interface bfa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::MODE_W-1:0]  fit_mode;

  modport source (output valid, output fit_mode, input ready);
  modport sink   (input valid, input fit_mode, output ready);
endinterface

`default_nettype wire

// ===== src/bfa_req_if.sv =====
// Request channel: allocate or free a run of cells.
`default_nettype none

interface bfa_req_if;
  logic                       valid;
  logic                       ready;
  logic [bfa_pkg::REQ_W-1:0]  req_type;
  logic [bfa_pkg::LEN_W-1:0]  run_length;
  logic [bfa_pkg::POS_W-1:0]  free_position;

  modport source (output valid, output req_type, output run_length,
                  output free_position, input ready);
  modport sink   (input valid, input req_type, input run_length,
                  input free_position, output ready);
endinterface

`default_nettype wire

// ===== src/bfa_rsp_if.sv =====
// Response channel: grant flag and run position.
`default_nettype none

interface bfa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [bfa_pkg::POS_W-1:0]  position;

  modport source (output valid, output granted, output position, input ready);
  modport sink   (input valid, input granted, input position, output ready);
endinterface

`default_nettype wire

// ===== src/bfa_map.sv =====
// Occupancy map held in a circular shift register, one cell out per cycle while shift_en_i is high.
`default_nettype none

module bfa_map #(
  parameter int unsigned CELLS = bfa_pkg::CELLS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_en_i,  // rotate by one cell
  input  logic new_bit_i,   // value written back for the head cell
  output logic head_o       // occupancy of the cell at the head
);

  logic [CELLS-1:0] map_q;

  assign head_o = map_q[0];

  // Rotate: the head cell re-enters at the top with its new value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (shift_en_i) begin
      map_q <= {new_bit_i, map_q[CELLS-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== src/bfa_scan.sv =====
// Bit-serial free-run tracker: measures each run and keeps the best candidate.
`default_nettype none

module bfa_scan #(
  parameter int unsigned CELLS = bfa_pkg::CELLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bfa_pkg::scan_ctl_t                 ctl_i,
  input  logic [$clog2(CELLS+1)-1:0]         idx_i,
  input  logic [bfa_pkg::LEN_W-1:0]          len_i,
  input  logic [$clog2(CELLS)-1:0]           rover_i,
  input  bfa_pkg::fit_e                      mode_i,
  output logic                               found_o,
  output logic [$clog2(CELLS)-1:0]           where_o,
  output logic                               found_b_o,
  output logic [$clog2(CELLS)-1:0]           where_b_o
);
  import bfa_pkg::*;

  localparam int unsigned IDX_W = $clog2(CELLS + 1);
  localparam int unsigned ADR_W = $clog2(CELLS);
  localparam int unsigned CW    = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  logic             in_run_q;
  logic [ADR_W-1:0] start_q;
  logic             found_q;
  logic [ADR_W-1:0] where_q;
  logic [IDX_W-1:0] best_q;
  logic             found_b_q;
  logic [ADR_W-1:0] where_b_q;

  logic [IDX_W-1:0] run_len;
  logic             run_end;
  logic             fits;
  logic             past_rover;
  logic             upd;
  logic             upd_b;

  // Run ends when an occupied cell (or the end marker) follows free cells
  always_comb begin
    run_len    = idx_i - IDX_W'(start_q);
    run_end    = ctl_i.step && ctl_i.occ && in_run_q;
    fits       = CW'(run_len) >= CW'(len_i);
    past_rover = idx_i >= IDX_W'(rover_i);
    upd        = run_end && fits &&
                 (!found_q ||
                  (mode_i == FIT_BEST  && run_len < best_q) ||
                  (mode_i == FIT_WORST && run_len > best_q));
    upd_b      = run_end && fits && past_rover && !found_b_q;
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q  <= 1'b0;
      found_q   <= 1'b0;
      found_b_q <= 1'b0;
    end else if (ctl_i.clear) begin
      in_run_q  <= 1'b0;
      found_q   <= 1'b0;
      found_b_q <= 1'b0;
    end else if (ctl_i.step) begin
      in_run_q <= !ctl_i.occ;
      if (upd)   found_q   <= 1'b1;
      if (upd_b) found_b_q <= 1'b1;
    end
  end

  // Run start and candidate positions
  always_ff @(posedge clk_i) begin
    if (ctl_i.step && !ctl_i.occ && !in_run_q) begin
      start_q <= idx_i[ADR_W-1:0];
    end
    if (upd) begin
      where_q <= start_q;
      best_q  <= run_len;
    end
    if (upd_b) begin
      where_b_q <= start_q;
    end
  end

  assign found_o   = found_q;
  assign where_o   = where_q;
  assign found_b_o = found_b_q;
  assign where_b_o = where_b_q;

endmodule

`default_nettype wire

// ===== src/bitmap_fit_allocator_core.sv =====
// Top level of the bitmap fit allocator: sequencer, rover and result register.
//
//   channel | dir | handshake    | payload
//   cfg_i   | in  | valid/ready  | fit_mode
//   req_i   | in  | valid/ready  | req_type, run_length, free_position
//   rsp_o   | out | valid/ready  | granted, position
//
// The map rotates through a shift register one cell per cycle while scanning or
// marking. Free: one write pass. Allocate: one scan pass over CELLS+1 steps,
// a pick step and one write pass, with no write pass when no run fits; an
// allocate with zero or oversize length goes straight to the result state.
// Reset empties the map, clears the rover and selects first fit.
// A new request is taken as soon as the sequencer is idle, while a result
// may still wait in the output register; a stalled output holds the
// sequencer before it loads the next result.
`default_nettype none

module bitmap_fit_allocator_core #(
  parameter int unsigned CELLS = bfa_pkg::CELLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_cfg_if.sink    cfg_i,
  bfa_req_if.sink    req_i,
  bfa_rsp_if.source  rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned IDX_W = $clog2(CELLS + 1);
  localparam int unsigned ADR_W = $clog2(CELLS);
  localparam int unsigned LO_W  = (ADR_W > POS_W) ? ADR_W : POS_W;
  localparam int unsigned SUM_W = ((LO_W > LEN_W) ? LO_W : LEN_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_MARK,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic [ADR_W-1:0] rover_q;
  fit_e             fit_mode_q;
  logic             out_valid_q;

  logic [LEN_W-1:0] len_q;
  logic [LO_W-1:0]  lo_q;
  logic             mark_v_q;
  logic             ok_q;
  logic [POS_W-1:0] pos_q;
  logic             granted_q;
  logic [POS_W-1:0] position_q;

  logic             req_fire;
  logic             len_ok;
  logic             out_load;
  logic             at_end;
  logic             mark_last;
  logic             in_range;
  logic             head;
  logic             new_bit;
  logic             shift_en;
  scan_ctl_t        scan_ctl;
  logic             found;
  logic [ADR_W-1:0] where_a;
  logic             found_b;
  logic [ADR_W-1:0] where_b;
  logic             pick_found;
  logic [ADR_W-1:0] pick_where;
  logic [SUM_W-1:0] rover_sum;
  logic [ADR_W-1:0] rover_next;

  // Handshakes
  assign cfg_i.ready   = 1'b1;
  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.granted = granted_q;
  assign rsp_o.position = position_q;

  // Sequencing conditions and the write window of the mark pass
  always_comb begin
    req_fire  = req_i.valid && req_i.ready;
    len_ok    = (req_i.run_length != '0) &&
                (SUM_W'(req_i.run_length) <= SUM_W'(CELLS));
    out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp_o.ready);
    at_end    = (idx_q == IDX_W'(CELLS));
    mark_last = (idx_q == IDX_W'(CELLS - 1));
    in_range  = (SUM_W'(idx_q) >= SUM_W'(lo_q)) &&
                (SUM_W'(idx_q) < SUM_W'(lo_q) + SUM_W'(len_q));
  end

  // Map rotation: plain rotate while scanning, write-back while marking
  always_comb begin
    shift_en = ((state_q == ST_SCAN) && !at_end) || (state_q == ST_MARK);
    new_bit  = ((state_q == ST_MARK) && in_range) ? mark_v_q : head;
  end

  // Scanner control; the end marker closes a run that reaches the last cell
  always_comb begin
    scan_ctl.clear = req_fire;
    scan_ctl.step  = (state_q == ST_SCAN);
    scan_ctl.occ   = at_end || head;
  end

  // Next fit prefers runs from the rover's run onward, then wraps
  always_comb begin
    if (fit_mode_q == FIT_NEXT) begin
      pick_found = found_b || found;
      pick_where = found_b ? where_b : where_a;
    end else begin
      pick_found = found;
      pick_where = where_a;
    end
    rover_sum  = SUM_W'(pick_where) + SUM_W'(len_q);
    rover_next = (rover_sum == SUM_W'(CELLS)) ? '0 : rover_sum[ADR_W-1:0];
  end

  bfa_map #(
    .CELLS (CELLS)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (shift_en),
    .new_bit_i  (new_bit),
    .head_o     (head)
  );

  bfa_scan #(
    .CELLS (CELLS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (idx_q),
    .len_i     (len_q),
    .rover_i   (rover_q),
    .mode_i    (fit_mode_q),
    .found_o   (found),
    .where_o   (where_a),
    .found_b_o (found_b),
    .where_b_o (where_b)
  );

  // State, cell index, rover, policy and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rover_q     <= '0;
      fit_mode_q  <= FIT_FIRST;
      out_valid_q <= 1'b0;
      granted_q   <= 1'b0;
      position_q  <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        fit_mode_q <= fit_e'(cfg_i.fit_mode);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        granted_q   <= ok_q;
        position_q  <= pos_q;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (req_fire) begin
            if (req_i.req_type == REQ_FREE) begin
              state_q <= ST_MARK;
            end else if (len_ok) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          if (at_end) begin
            state_q <= ST_PICK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_PICK: begin
          idx_q <= '0;
          if (pick_found) begin
            state_q <= ST_MARK;
            if (fit_mode_q == FIT_NEXT) begin
              rover_q <= rover_next;
            end
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_MARK: begin
          if (mark_last) begin
            state_q <= ST_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Request fields and pending result
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      len_q    <= req_i.run_length;
      lo_q     <= LO_W'(req_i.free_position);
      mark_v_q <= (req_i.req_type == REQ_ALLOC);
      ok_q     <= (req_i.req_type == REQ_FREE);
      pos_q    <= (req_i.req_type == REQ_FREE) ? req_i.free_position : '0;
    end
    if (state_q == ST_PICK && pick_found) begin
      lo_q  <= LO_W'(pick_where);
      ok_q  <= 1'b1;
      pos_q <= POS_W'(pick_where);
    end
  end

  // A granted run never reaches past the last cell
  a_pick_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK && pick_found) |->
      (SUM_W'(pick_where) + SUM_W'(len_q) <= SUM_W'(CELLS)))
    else $error("granted run extends past the end of the store");

  // The write pass walks every cell exactly once
  a_mark_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK && !mark_last) |=>
      (state_q == ST_MARK && idx_q == $past(idx_q) + 1'b1))
    else $error("write pass skipped or repeated a cell");

  // Every accepted item leaves idle on the next cycle
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != ST_IDLE))
    else $error("accepted item did not start processing");

endmodule

`default_nettype wire
